[rtl/color_bitmap_descriptor_extract_core_defines.svh]
// Assertion macros for the colour bitmap descriptor core
`ifndef COLOR_BITMAP_DESCRIPTOR_EXTRACT_CORE_DEFINES_SVH
`define COLOR_BITMAP_DESCRIPTOR_EXTRACT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CBDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define CBDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBDE_ASSERT_NOW(lbl, ante, cons, msg)
`define CBDE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/cbde_pkg.sv]
package cbde_pkg;

    localparam int NUM_BLOCKS = 10;
    localparam int COUNT_BITS = 24;
    localparam int CNT_W      = 24;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int NCH        = 3;
    localparam int BM_W       = 10;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 40;
    localparam int PRD_W      = 64;
    localparam int DVD_W      = 80;
    localparam int DVS_W      = 48;
    localparam int REM_W      = 50;
    localparam int STEP_W     = 7;
    localparam int OUT_W      = 16;

    localparam logic [CNT_W-1:0]  CNT_MASK  = CNT_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [CNT_W-1:0]  NB_CNT    = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(64);
    localparam logic [BLK_W-1:0]  LAST_BLK  = BLK_W'(NUM_BLOCKS - 1);
    localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(32);
    localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(80);
    localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(32);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cbde_pixel_t;

    typedef struct packed {
        logic [OUT_W-1:0] mean_red;
        logic [OUT_W-1:0] mean_green;
        logic [OUT_W-1:0] mean_blue;
        logic [OUT_W-1:0] dev_red;
        logic [OUT_W-1:0] dev_green;
        logic [OUT_W-1:0] dev_blue;
        logic [BM_W-1:0]  bitmap_red;
        logic [BM_W-1:0]  bitmap_green;
        logic [BM_W-1:0]  bitmap_blue;
    } cbde_result_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } cbde_alu_op_t;

    typedef struct packed {
        logic             start;
        cbde_alu_op_t     op;
        logic [DVD_W-1:0] a;
        logic [DVS_W-1:0] b;
    } cbde_alu_req_t;

    typedef struct packed {
        logic             done;
        logic [PRD_W-1:0] res;
    } cbde_alu_rsp_t;

    typedef enum logic [3:0] {
        ST_SETUP_N,
        ST_SETUP_LN,
        ST_SETUP_M,
        ST_IDLE,
        ST_MEAN,
        ST_SQS,
        ST_NQ,
        ST_VAR,
        ST_SQRT,
        ST_RD,
        ST_BCNT,
        ST_SBN,
        ST_OUT
    } cbde_state_t;

endpackage

[rtl/cbde_alu.sv]
module cbde_alu import cbde_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  cbde_alu_req_t req,
    output cbde_alu_rsp_t rsp
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    cbde_alu_op_t       op_reg, op_next;
    logic [DVD_W-1:0]   x_reg, x_next;
    logic [DVS_W-1:0]   y_reg, y_next;
    logic [PRD_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   trial, subtr, diff;
    logic               ge;

    // shared compare/subtract for division and root
    always_comb begin
        if (op_reg == ALU_DIV) begin
            trial = {rem_reg[REM_W-2:0], x_reg[DVD_W-1]};
            subtr = {2'b00, y_reg};
        end else begin
            trial = {rem_reg[REM_W-3:0], x_reg[DVD_W-1:DVD_W-2]};
            subtr = {16'd0, acc_reg[31:0], 2'b01};
        end
        ge   = (trial >= subtr);
        diff = trial - subtr;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            x_next    = (req.op == ALU_SQRT) ? {req.a[PRD_W-1:0], 16'd0} : req.a;
            y_next    = req.b;
            acc_next  = '0;
            rem_next  = '0;
            unique case (req.op)
                ALU_MUL:  step_next = MUL_STEPS - STEP_W'(1);
                ALU_DIV:  step_next = DIV_STEPS - STEP_W'(1);
                ALU_SQRT: step_next = SQRT_STEPS - STEP_W'(1);
                default:  step_next = '0;
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                ALU_MUL: begin
                    if (y_reg[0]) begin
                        acc_next = acc_reg + x_reg[PRD_W-1:0];
                    end
                    x_next = {x_reg[DVD_W-2:0], 1'b0};
                    y_next = {1'b0, y_reg[DVS_W-1:1]};
                end
                ALU_DIV: begin
                    rem_next = ge ? diff : trial;
                    acc_next = {acc_reg[PRD_W-2:0], ge};
                    x_next   = {x_reg[DVD_W-2:0], 1'b0};
                end
                ALU_SQRT: begin
                    rem_next = ge ? diff : trial;
                    acc_next = {acc_reg[PRD_W-2:0], ge};
                    x_next   = {x_reg[DVD_W-3:0], 2'b00};
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule

[rtl/cbde_accum.sv]
module cbde_accum import cbde_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          take,
    input  cbde_pixel_t                   pixel,
    input  logic                          clear,
    input  logic [CNT_W-1:0]              cnt,
    input  logic [CNT_W-1:0]              n,
    input  logic [BLK_W-1:0]              rd_addr,
    output logic [NCH-1:0][SUM_W-1:0]     sum,
    output logic [NCH-1:0][SQ_W-1:0]      sq,
    output logic [NCH-1:0][SUM_W-1:0]     rd_data,
    output logic                          full
);

    logic [NCH-1:0][SUM_W-1:0] sum_reg, sum_next, sum_add;
    logic [NCH-1:0][SQ_W-1:0]  sq_reg, sq_next, sq_add;
    logic [NCH-1:0][SUM_W-1:0] blk_reg, blk_next, blk_add;
    logic [NCH-1:0][7:0]       pv;
    logic [CNT_W-1:0]          ibc_reg, ibc_next, ibc_inc;
    logic [CNT_W-1:0]          pidx_reg, pidx_next, pidx_inc;
    logic [BLK_W-1:0]          bi_reg, bi_next;
    logic                      full_reg, full_next;
    logic                      adv, last, wr;
    logic [NCH-1:0][SUM_W-1:0] mem [NUM_BLOCKS];
    logic [NCH-1:0][SUM_W-1:0] rd_data_reg;

    always_comb begin
        pv[0] = pixel.red;
        pv[1] = pixel.green;
        pv[2] = pixel.blue;
        for (int c = 0; c < NCH; c++) begin
            sum_add[c] = sum_reg[c] + SUM_W'(pv[c]);
            sq_add[c]  = sq_reg[c] + SQ_W'({8'd0, pv[c]} * {8'd0, pv[c]});
            blk_add[c] = blk_reg[c] + SUM_W'(pv[c]);
        end
        ibc_inc  = ibc_reg + CNT_W'(1);
        pidx_inc = pidx_reg + CNT_W'(1);
        adv      = (bi_reg < LAST_BLK) && (ibc_inc >= n);
        last     = (pidx_inc == cnt);
        wr       = take && (adv || last);

        sum_next  = sum_reg;
        sq_next   = sq_reg;
        blk_next  = blk_reg;
        ibc_next  = ibc_reg;
        pidx_next = pidx_reg;
        bi_next   = bi_reg;
        full_next = full_reg;
        if (clear) begin
            sum_next  = '0;
            sq_next   = '0;
            blk_next  = '0;
            ibc_next  = '0;
            pidx_next = '0;
            bi_next   = '0;
            full_next = 1'b0;
        end else if (take) begin
            sum_next  = sum_add;
            sq_next   = sq_add;
            blk_next  = adv ? '0 : blk_add;
            ibc_next  = adv ? '0 : ibc_inc;
            bi_next   = adv ? bi_reg + BLK_W'(1) : bi_reg;
            pidx_next = pidx_inc;
            full_next = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            blk_reg  <= '0;
            ibc_reg  <= '0;
            pidx_reg <= '0;
            bi_reg   <= '0;
            full_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
            blk_reg  <= blk_next;
            ibc_reg  <= ibc_next;
            pidx_reg <= pidx_next;
            bi_reg   <= bi_next;
            full_reg <= full_next;
        end
    end

    // block sums, written as each block closes
    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[bi_reg] <= blk_add;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign sum     = sum_reg;
    assign sq      = sq_reg;
    assign rd_data = rd_data_reg;
    assign full    = full_reg;

endmodule

[rtl/cbde_finish.sv]
module cbde_finish import cbde_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CNT_W-1:0]          cnt,
    input  logic                      full,
    input  logic [NCH-1:0][SUM_W-1:0] sum,
    input  logic [NCH-1:0][SQ_W-1:0]  sq,
    input  logic [NCH-1:0][SUM_W-1:0] rd_data,
    input  cbde_alu_rsp_t             rsp,
    input  logic                      m_ready,
    output logic [CNT_W-1:0]          n,
    output logic [BLK_W-1:0]          rd_addr,
    output logic                      clear,
    output logic                      s_ready,
    output cbde_alu_req_t             req,
    output logic                      m_valid,
    output cbde_result_t              m_data
);

    cbde_state_t               state_reg, state_next;
    logic                      pend_reg, pend_next;
    logic [1:0]                c_reg, c_next;
    logic [BLK_W-1:0]          k_reg, k_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          ln_reg, ln_next;
    logic [DVS_W-1:0]          m_reg, m_next;
    logic [PRD_W-1:0]          t_reg, t_next;
    logic [PRD_W-1:0]          d_reg, d_next;
    logic [NCH-1:0][OUT_W-1:0] mean_reg, mean_next;
    logic [NCH-1:0][OUT_W-1:0] dev_reg, dev_next;
    logic [NCH-1:0][BM_W-1:0]  bm_reg, bm_next;
    logic                      m_valid_reg, m_valid_next;
    cbde_result_t              m_data_reg, m_data_next;
    logic [SUM_W-1:0]          sel_sum, sel_bs;
    logic [SQ_W-1:0]           sel_sq;
    logic [CNT_W-1:0]          bn;
    logic [OUT_W-1:0]          res_sat;
    logic                      go;

    always_comb begin
        sel_sum = sum[c_reg];
        sel_sq  = sq[c_reg];
        sel_bs  = rd_data[c_reg];
        bn      = (k_reg == LAST_BLK) ? ln_reg : n_reg;
        res_sat = (|rsp.res[PRD_W-1:OUT_W]) ? '1 : rsp.res[OUT_W-1:0];
        go      = pend_reg && rsp.done;

        state_next   = state_reg;
        pend_next    = pend_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        ln_next      = ln_reg;
        m_next       = m_reg;
        t_next       = t_reg;
        d_next       = d_reg;
        mean_next    = mean_reg;
        dev_next     = dev_reg;
        bm_next      = bm_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        clear        = 1'b0;
        req.start    = 1'b0;
        req.op       = ALU_MUL;
        req.a        = '0;
        req.b        = '0;

        unique case (state_reg)
            ST_SETUP_N: begin
                req.start = !pend_reg;
                req.op    = ALU_DIV;
                req.a     = DVD_W'(cnt);
                req.b     = DVS_W'(NB_CNT);
                pend_next = !go;
                if (go) begin
                    n_next     = rsp.res[CNT_W-1:0];
                    state_next = ST_SETUP_LN;
                end
            end
            ST_SETUP_LN: begin
                req.start = !pend_reg;
                req.a     = DVD_W'(n_reg);
                req.b     = DVS_W'(NUM_BLOCKS - 1);
                pend_next = !go;
                if (go) begin
                    ln_next    = cnt - rsp.res[CNT_W-1:0];
                    state_next = ST_SETUP_M;
                end
            end
            ST_SETUP_M: begin
                req.start = !pend_reg;
                req.a     = DVD_W'(cnt);
                req.b     = DVS_W'(cnt - CNT_W'(1));
                pend_next = !go;
                if (go) begin
                    m_next     = rsp.res[DVS_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (full) begin
                    c_next     = '0;
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                req.start = !pend_reg;
                req.op    = ALU_DIV;
                req.a     = {40'd0, sel_sum, 8'd0};
                req.b     = DVS_W'(cnt);
                pend_next = !go;
                if (go) begin
                    mean_next[c_reg] = res_sat;
                    bm_next[c_reg]   = '0;
                    state_next       = ST_SQS;
                end
            end
            ST_SQS: begin
                req.start = !pend_reg;
                req.a     = DVD_W'(sel_sum);
                req.b     = DVS_W'(sel_sum);
                pend_next = !go;
                if (go) begin
                    t_next     = rsp.res;
                    state_next = ST_NQ;
                end
            end
            ST_NQ: begin
                req.start = !pend_reg;
                req.a     = DVD_W'(sel_sq);
                req.b     = DVS_W'(cnt);
                pend_next = !go;
                if (go) begin
                    d_next     = (rsp.res > t_reg) ? rsp.res - t_reg : '0;
                    state_next = ST_VAR;
                end
            end
            ST_VAR: begin
                req.start = !pend_reg;
                req.op    = ALU_DIV;
                req.a     = {d_reg, 16'd0};
                req.b     = m_reg;
                pend_next = !go;
                if (go) begin
                    d_next     = rsp.res;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                req.start = !pend_reg;
                req.op    = ALU_SQRT;
                req.a     = DVD_W'(d_reg);
                pend_next = !go;
                if (go) begin
                    dev_next[c_reg] = res_sat;
                    k_next          = '0;
                    state_next      = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_BCNT;
            end
            ST_BCNT: begin
                req.start = !pend_reg;
                req.a     = DVD_W'(sel_bs);
                req.b     = DVS_W'(cnt);
                pend_next = !go;
                if (go) begin
                    t_next     = rsp.res;
                    state_next = ST_SBN;
                end
            end
            ST_SBN: begin
                req.start = !pend_reg;
                req.a     = DVD_W'(sel_sum);
                req.b     = DVS_W'(bn);
                pend_next = !go;
                if (go) begin
                    if (t_reg > rsp.res) begin
                        bm_next[c_reg] = bm_reg[c_reg] | (BM_W'(1) << k_reg);
                    end
                    if (k_reg == LAST_BLK) begin
                        if (c_reg == 2'(NCH - 1)) begin
                            state_next = ST_OUT;
                        end else begin
                            c_next     = c_reg + 2'd1;
                            state_next = ST_MEAN;
                        end
                    end else begin
                        k_next     = k_reg + BLK_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    m_data_next.mean_red     = mean_reg[0];
                    m_data_next.mean_green   = mean_reg[1];
                    m_data_next.mean_blue    = mean_reg[2];
                    m_data_next.dev_red      = dev_reg[0];
                    m_data_next.dev_green    = dev_reg[1];
                    m_data_next.dev_blue     = dev_reg[2];
                    m_data_next.bitmap_red   = bm_reg[0];
                    m_data_next.bitmap_green = bm_reg[1];
                    m_data_next.bitmap_blue  = bm_reg[2];
                    m_valid_next             = 1'b1;
                    clear                    = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SETUP_N;
            end
        endcase

        if (cfg_wr_en) begin
            state_next = ST_SETUP_N;
            pend_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SETUP_N;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg      <= c_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        ln_reg     <= ln_next;
        m_reg      <= m_next;
        t_reg      <= t_next;
        d_reg      <= d_next;
        mean_reg   <= mean_next;
        dev_reg    <= dev_next;
        bm_reg     <= bm_next;
        m_data_reg <= m_data_next;
    end

    assign n       = n_reg;
    assign rd_addr = k_reg;
    assign s_ready = (state_reg == ST_IDLE) && !full;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/color_bitmap_descriptor_extract_core.sv]
// Colour bitmap descriptor core. Pixels of one image stream in on the s_ beat
// channel, one per cycle while s_ready is high, while per-channel sums, sums
// of squares and block sums build up; the image ends after pixel_count pixels
// (values below the block count act as the block count). The last pixel
// starts a finish pass on one shared multiply/divide/square-root unit that
// works one bit per cycle: per channel a 80-step divide for the mean, two
// 32-step multiplies, an 80-step divide and a 32-step root for the deviation,
// then a block-sum read and two 32-step multiplies per block for the bitmap.
// No pixel is taken during the pass. The result then sits in an output
// register so the next image may start while it waits. After reset or a
// pixel_count write the block works out block sizes and the variance divisor
// before it takes the first pixel.
`include "color_bitmap_descriptor_extract_core_defines.svh"

module color_bitmap_descriptor_extract_core import cbde_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  cbde_pixel_t        s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cbde_result_t       m_data
);

    logic [CNT_W-1:0]          pixel_count_reg;
    logic [CNT_W-1:0]          masked, cnt, n;
    logic                      take, clear_fin, acc_full;
    logic [BLK_W-1:0]          rd_addr;
    logic [NCH-1:0][SUM_W-1:0] sum, rd_data;
    logic [NCH-1:0][SQ_W-1:0]  sq;
    cbde_alu_req_t             req;
    cbde_alu_rsp_t             rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= CNT_RESET;
        end else if (cfg_wr_en) begin
            pixel_count_reg <= cfg_wr_data;
        end
    end

    assign masked = pixel_count_reg & CNT_MASK;
    assign cnt    = (masked < NB_CNT) ? NB_CNT : masked;
    assign take   = s_valid && s_ready;

    cbde_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .pixel   (s_data),
        .clear   (clear_fin || cfg_wr_en),
        .cnt     (cnt),
        .n       (n),
        .rd_addr (rd_addr),
        .sum     (sum),
        .sq      (sq),
        .rd_data (rd_data),
        .full    (acc_full)
    );

    cbde_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    cbde_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cnt       (cnt),
        .full      (acc_full),
        .sum       (sum),
        .sq        (sq),
        .rd_data   (rd_data),
        .rsp       (rsp),
        .m_ready   (m_ready),
        .n         (n),
        .rd_addr   (rd_addr),
        .clear     (clear_fin),
        .s_ready   (s_ready),
        .req       (req),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    `CBDE_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr_en, !s_ready, "pixel taken during setup")
    `CBDE_ASSERT_NOW(a_result_needs_image, $rose(m_valid), $past(acc_full), "result without image")
    `CBDE_ASSERT_NOW(a_full_blocks_input, acc_full, !s_ready, "pixel taken past image end")

endmodule
